// ===== rtl/core/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue: operation and status
// codes, result field widths and the per-cycle control word of the cell row.
// ----------------------------------------------------------------------------
package dq_pkg;

	// result field widths
	localparam int DQ_DATA_W    = 32;
	localparam int DQ_STATUS_W  = 2;
	localparam int DQ_ENTRIES_W = 5;

	// operation codes carried in s_tuser
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_BACK  = 2'd2,
		OP_POP_BACK   = 2'd3
	} dq_op_t;

	// result status codes
	typedef enum logic [DQ_STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} dq_status_t;

	// qualified moves broadcast to every cell, at most one set per cycle
	typedef struct packed {
		logic push_front;
		logic pop_front;
		logic push_back;
		logic pop_back;
	} dq_ctrl_t;

endpackage

// ===== rtl/core/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the queue row. Cell 0 is the front; occupied cells form a
// contiguous run from cell 0. Front moves shift the row by one place, back
// moves touch only the boundary cell of the run.
// ----------------------------------------------------------------------------
module dq_cell
	import dq_pkg::*;
#(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  dq_ctrl_t     ctrl,
	input  logic [W-1:0] word,        // data of a push
	input  logic [W-1:0] prev_data,   // neighbor toward the front
	input  logic         prev_valid,
	input  logic [W-1:0] next_data,   // neighbor toward the back
	input  logic         next_valid,
	output logic [W-1:0] data,
	output logic         valid,
	output logic [W-1:0] tail_data    // own data if this is the back cell, else 0
);

	logic [W-1:0] data_q;
	logic         valid_q;
	logic         is_tail;

	assign is_tail = valid_q && !next_valid;

	// occupancy: stays a run from cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (ctrl.push_front) begin
				valid_q <= prev_valid;
			end else if (ctrl.pop_front) begin
				valid_q <= next_valid;
			end else if (ctrl.push_back) begin
				valid_q <= valid_q | prev_valid;
			end else if (ctrl.pop_back) begin
				valid_q <= valid_q & next_valid;
			end
		end
	end

	// payload: shifted on front moves, loaded at the first free cell on push back
	always_ff @(posedge clk) begin
		priority if (ctrl.push_front) begin
			data_q <= prev_data;
		end else if (ctrl.pop_front) begin
			data_q <= next_data;
		end else if (ctrl.push_back && !valid_q && prev_valid) begin
			data_q <= word;
		end
	end

	assign data      = data_q;
	assign valid     = valid_q;
	assign tail_data = is_tail ? data_q : '0;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue held in a row of shifting cells. Each input
// transfer pushes or pops at either end and yields one result transfer with
// the popped word, a status and the entry count after the operation.
//
//  channel | dir | tdata (low bit up)               | tuser
//  s_*     | in  | push_data[31:0]                  | operation[1:0]
//  m_*     | out | pop_data[31:0], status[1:0],     | -
//          |     | entries[4:0], 1 zero pad bit     |
//
// One operation per cycle while s_tready is high: the cell row updates in the
// accepting cycle and the result lands in the output register on the same edge.
// m_tvalid is registered and rises in the cycle after the input transfer.
// s_tready is high while the output register is empty or being drained, so
// a stall on m_tready holds the input after one buffered result.
// Reset empties the queue; stored words are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // push_data[31:0]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // pop_data[31:0], status[33:32], entries[38:34], pad
);

	localparam int SW = (DATA_WIDTH < DQ_DATA_W) ? DATA_WIDTH : DQ_DATA_W;
	localparam int CW = $clog2(DEPTH + 1);

	dq_op_t      op;
	logic        s_fire;
	logic        is_push;
	logic        full;
	logic        empty;
	logic        ok;
	dq_ctrl_t    ctrl;
	dq_status_t  status;
	logic [SW-1:0] word;
	logic [SW-1:0] cell_data [DEPTH];
	logic [SW-1:0] cell_tail [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	logic [SW-1:0] tail_or;
	logic [SW-1:0] popped;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          m_valid_q;
	logic [39:0]   m_data_q;

	assign op      = dq_op_t'(s_tuser);
	assign word    = s_tdata[SW-1:0];
	assign s_fire  = s_tvalid && s_tready;
	assign is_push = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
	assign full    = cell_valid[DEPTH-1];
	assign empty   = !cell_valid[0];
	assign ok      = is_push ? !full : !empty;

	// qualified moves for the row
	always_comb begin
		ctrl            = '0;
		ctrl.push_front = s_fire && ok && (op == OP_PUSH_FRONT);
		ctrl.pop_front  = s_fire && ok && (op == OP_POP_FRONT);
		ctrl.push_back  = s_fire && ok && (op == OP_PUSH_BACK);
		ctrl.pop_back   = s_fire && ok && (op == OP_POP_BACK);
	end

	// cell row, front at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [SW-1:0] prev_d;
		logic          prev_v;
		logic [SW-1:0] next_d;
		logic          next_v;

		if (i == 0) begin : g_head
			assign prev_d = word;
			assign prev_v = 1'b1;
		end else begin : g_mid_p
			assign prev_d = cell_data[i-1];
			assign prev_v = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = '0;
			assign next_v = 1'b0;
		end else begin : g_mid_n
			assign next_d = cell_data[i+1];
			assign next_v = cell_valid[i+1];
		end

		dq_cell #(.W(SW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.word       (word),
			.prev_data  (prev_d),
			.prev_valid (prev_v),
			.next_data  (next_d),
			.next_valid (next_v),
			.data       (cell_data[i]),
			.valid      (cell_valid[i]),
			.tail_data  (cell_tail[i])
		);
	end

	// back word: at most one cell drives a nonzero tail
	always_comb begin
		tail_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_or = tail_or | cell_tail[i];
		end
	end

	// result of this operation
	always_comb begin
		popped = '0;
		if (ctrl.pop_front) begin
			popped = cell_data[0];
		end else if (ctrl.pop_back) begin
			popped = tail_or;
		end
		if (ok) begin
			status = ST_OK;
		end else if (is_push) begin
			status = ST_FULL;
		end else begin
			status = ST_EMPTY;
		end
		count_next = count_q;
		if (ctrl.push_front || ctrl.push_back) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.pop_front || ctrl.pop_back) begin
			count_next = count_q - CW'(1);
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// output register
	assign s_tready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_data_q <= {1'b0, DQ_ENTRIES_W'(count_next), status, DQ_DATA_W'(popped)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTHESIS
	// counter tracks the occupied cells
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(count_q))
		else $error("entry count differs from occupied cells");

	// occupied cells form a run from the front
	a_run_from_front: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_valid & ~(cell_valid >> 1)) && (cell_valid == '0 || cell_valid[0]))
		else $error("occupied cells not contiguous");

	// a good push grows the queue by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.push_front || ctrl.push_back) |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not add an entry");

	// an empty-pop result reports no entries
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_data_q[33:32] == ST_EMPTY) |-> m_data_q[38:34] == '0)
		else $error("empty status with nonzero entries");
`endif

endmodule

// ===== tb/tb_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the double-ended queue. A short directed sequence
// hits the empty, full, single-entry and wrap cases, then random push and
// pop bursts walk the queue between empty and full. Every transfer is
// predicted by a local deque model, and each result transfer is checked
// field by field against the oldest prediction, under random idling on
// both stream sides in the first two phases.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import dq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 1330;
	localparam int PHASE_LEN    = 450;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		dq_op_t      op;
		logic [31:0] word;
	} dq_item_t;

	typedef struct {
		logic [31:0] pop_data;
		dq_status_t  status;
		logic [4:0]  entries;
	} dq_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // push_data[31:0]
	logic [1:0]  s_tuser  = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // pop_data[31:0], status[33:32], entries[38:34], pad

	// stimulus and expectation stores
	dq_item_t   op_backlog[$];
	dq_result_t pending_results[$];
	int         mismatch_count = 0;
	int         sent_count     = 0;
	int         cycle_count    = 0;
	logic       in_fired       = 1'b0;
	int         send_idle_pct;
	int         recv_idle_pct;
	dq_result_t want;

	// local deque model state
	logic [31:0] slot_words[DEPTH];
	logic [3:0]  head_slot = '0;
	logic [3:0]  tail_slot = '0;
	logic [4:0]  fill      = '0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	double_ended_queue #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (32)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("MISMATCH %s: got %h, expected %h (t=%0t)", what, got, exp_val, $realtime);
		mismatch_count++;
	endtask

	// apply one operation to the local deque and return its result
	function automatic dq_result_t deque_apply(dq_op_t op, logic [31:0] word);
		dq_result_t r;
		r.pop_data = '0;
		r.status   = ST_OK;
		if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && fill == DEPTH) begin
			r.status = ST_FULL;
		end else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && fill == 0) begin
			r.status = ST_EMPTY;
		end else begin
			case (op)
				OP_PUSH_FRONT: begin
					head_slot = head_slot - 4'd1;
					slot_words[head_slot] = word;
					fill = fill + 5'd1;
				end
				OP_POP_FRONT: begin
					r.pop_data = slot_words[head_slot];
					head_slot = head_slot + 4'd1;
					fill = fill - 5'd1;
				end
				OP_PUSH_BACK: begin
					slot_words[tail_slot] = word;
					tail_slot = tail_slot + 4'd1;
					fill = fill + 5'd1;
				end
				default: begin
					tail_slot = tail_slot - 4'd1;
					r.pop_data = slot_words[tail_slot];
					fill = fill - 5'd1;
				end
			endcase
		end
		r.entries = fill;
		return r;
	endfunction

	// monitor: check result transfers, predict on input transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata[31:0], '0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[31:0] !== want.pop_data)
						report_mismatch("pop_data", m_tdata[31:0], want.pop_data);
					if (m_tdata[33:32] !== want.status)
						report_mismatch("status", 32'(m_tdata[33:32]), 32'(want.status));
					if (m_tdata[38:34] !== want.entries)
						report_mismatch("entries", 32'(m_tdata[38:34]), 32'(want.entries));
				end
			end
			in_fired = s_tvalid && s_tready;
			if (in_fired)
				pending_results.push_back(deque_apply(dq_op_t'(s_tuser), s_tdata));
		end else begin
			in_fired = 1'b0;
		end
	end

	// driver: present queued items and toggle m_tready on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fired) begin
				void'(op_backlog.pop_front());
				sent_count++;
			end
			if (sent_count < PHASE_LEN) begin
				send_idle_pct = 19;
				recv_idle_pct = 82;
			end else if (sent_count < 2 * PHASE_LEN) begin
				send_idle_pct = 82;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// a stalled transfer holds its data
			if (!(s_tvalid && !in_fired)) begin
				if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser  <= op_backlog[0].op;
					s_tdata  <= op_backlog[0].word;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// run timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("double_ended_queue test failed");
			$finish;
		end
	end

	initial begin
		int          n;
		int          burst;
		int          lean;
		int          pick;
		logic        is_push;
		logic        at_front;
		dq_op_t      op;
		logic [31:0] word;

		// directed: empty pops, single entry at either end, fill with wrap, full pushes
		op_backlog.push_back('{OP_POP_FRONT, 32'h1234_5678});
		op_backlog.push_back('{OP_POP_BACK, 32'hFFFF_FFFF});
		op_backlog.push_back('{OP_PUSH_FRONT, 32'hFFFF_FFFF});
		op_backlog.push_back('{OP_POP_BACK, 32'h0});
		op_backlog.push_back('{OP_PUSH_BACK, 32'h0});
		op_backlog.push_back('{OP_POP_FRONT, 32'h0});
		for (n = 0; n < DEPTH; n++) begin
			case (n % 4)
				0: word = 32'hFFFF_FFFF;
				1: word = 32'h0;
				2: word = 32'hAAAA_AAAA;
				default: word = 32'h5555_5555;
			endcase
			op_backlog.push_back('{(n % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, word ^ n});
		end
		op_backlog.push_back('{OP_PUSH_FRONT, 32'hDEAD_0001});
		op_backlog.push_back('{OP_PUSH_BACK, 32'hDEAD_0002});

		// random bursts leaning toward pushes, pops or neither
		n = 0;
		while (n < RANDOM_ITEMS) begin
			burst = $urandom_range(24, 1);
			lean  = $urandom_range(2);
			for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
				pick     = $urandom_range(99);
				is_push  = (lean == 1) ? (pick < 80) : (lean == 0) ? (pick < 20) : (pick < 50);
				at_front = 1'($urandom_range(1));
				if (is_push)
					op = at_front ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else
					op = at_front ? OP_POP_FRONT : OP_POP_BACK;
				case ($urandom_range(9))
					0: word = '0;
					1: word = '1;
					default: word = $urandom();
				endcase
				op_backlog.push_back('{op, word});
				n++;
			end
		end

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		while (op_backlog.size() != 0 || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("double_ended_queue test passed");
		end else begin
			$display("double_ended_queue test failed");
		end
		$finish;
	end

endmodule
